/* rtl/tgmc_pkg.sv */
// ----------------------------------------------------------------------------
// tgmc_pkg
// Shared types, constants and helpers for the tile grid move clamp.
// ----------------------------------------------------------------------------
package tgmc_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    // widths fixed by the item fields
    localparam int POS_W   = 15;
    localparam int SIZE_W  = 12;
    localparam int DELTA_W = 13;
    localparam int LOG_W   = 3;
    localparam int SHIFT_W = 4;
    localparam int ALU_W   = 18;   // covers pos + size + delta and line * tile edge
    localparam int IDX_W   = 10;   // signed tile index after the shift

    localparam int DELTA_MAX = 4095;
    localparam int DELTA_MIN = -4096;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CLAMP = 1'b1;

    localparam logic AXIS_H = 1'b0;
    localparam logic AXIS_V = 1'b1;

    localparam logic [LOG_W-1:0] TILE_LOG_RST = 3'd5;
    localparam logic [LOG_W-1:0] TILE_LOG_MIN = 3'd3;
    localparam logic [LOG_W-1:0] TILE_LOG_MAX = 3'd5;

    localparam int  APB_DW          = 32;
    localparam int  APB_AW          = 3;
    localparam logic REG_TILE_SIZE  = 1'b0;   // word index bit of paddr

    typedef logic signed [ALU_W-1:0] t_alu_word;
    typedef logic signed [IDX_W-1:0] t_idx;

    // four-term add handed to the shared unit
    typedef struct packed {
        t_alu_word a;
        t_alu_word b;
        t_alu_word c;
        t_alu_word k;
    } t_alu_op;

    // wall memory control
    typedef struct packed {
        logic clr;   // zero a whole row
        logic wr;    // write one tile bit
        logic rd;    // read a row
    } t_mem_ctl;

    // tile edge log2 -> shift in Q.4 units
    function automatic logic [SHIFT_W-1:0] tile_shift(input logic [LOG_W-1:0] lg);
        logic [LOG_W-1:0] c;
        c = lg;
        if (lg < TILE_LOG_MIN) c = TILE_LOG_MIN;
        if (lg > TILE_LOG_MAX) c = TILE_LOG_MAX;
        return SHIFT_W'(c) + SHIFT_W'(4);
    endfunction

    function automatic logic signed [DELTA_W-1:0] sat_delta(input t_alu_word v);
        logic signed [DELTA_W-1:0] r;
        if (v > t_alu_word'(DELTA_MAX))      r = DELTA_W'(DELTA_MAX);
        else if (v < t_alu_word'(DELTA_MIN)) r = DELTA_W'(DELTA_MIN);
        else                                 r = DELTA_W'(v);
        return r;
    endfunction

endpackage

/* rtl/tgmc_alu.sv */
// ----------------------------------------------------------------------------
// tgmc_alu
// Shared four-term adder with a floor shift to a tile index.
// ----------------------------------------------------------------------------
module tgmc_alu import tgmc_pkg::*; (
    input  t_alu_op              i_op,
    input  logic [SHIFT_W-1:0]   i_shift,
    output t_alu_word            o_sum,
    output t_idx                 o_idx
);

    t_alu_word w_sum;
    t_alu_word w_shr;

    assign w_sum = i_op.a + i_op.b + i_op.c + i_op.k;
    // arithmetic shift is a floor division by the tile edge
    assign w_shr = w_sum >>> i_shift;
    assign o_sum = w_sum;
    assign o_idx = IDX_W'(w_shr);

endmodule

/* rtl/tgmc_wall_mem.sv */
// ----------------------------------------------------------------------------
// tgmc_wall_mem
// Wall bitmap, one row of tiles per word, bit writes, registered row read.
// ----------------------------------------------------------------------------
module tgmc_wall_mem import tgmc_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    localparam int COL_W = $clog2(GRID_COLS),
    localparam int ROW_W = $clog2(GRID_ROWS)
) (
    input  logic                 i_clk,
    input  t_mem_ctl             i_ctl,
    input  logic [ROW_W-1:0]     i_wr_row,
    input  logic [COL_W-1:0]     i_wr_col,
    input  logic                 i_wr_bit,
    input  logic [ROW_W-1:0]     i_rd_row,
    output logic [GRID_COLS-1:0] o_rd_data
);

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_mem[i_wr_row] <= '0;
        end else if (i_ctl.wr) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tile_grid_move_clamp.sv */
// Sequence: a write item or a zero move goes straight to the done step; a move query
//   computes the span and the entered tile line, then scans tiles up to the first wall
//   (one wall memory read each), with one flush step on a hit.
// Throughput: one item at a time; the next is taken once the current result is queued.
// Reset: synchronous, active low; tile size returns to 32 px, then a clearing pass
//   (one map row per cycle) zeroes the wall map while input is stalled.
// ----------------------------------------------------------------------------
// tile_grid_move_clamp
// Clamps a box move against a tile wall bitmap, one tile per cycle.
// ----------------------------------------------------------------------------
module tile_grid_move_clamp import tgmc_pkg::*; #(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic [5:0]                i_tile_col,
    input  logic [5:0]                i_tile_row,
    input  logic                      i_wall_bit,
    input  logic                      i_axis,
    input  logic [POS_W-1:0]          i_box_x,
    input  logic [POS_W-1:0]          i_box_y,
    input  logic [SIZE_W-1:0]         i_box_w,
    input  logic [SIZE_W-1:0]         i_box_h,
    input  logic signed [DELTA_W-1:0] i_move_delta,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DELTA_W-1:0] o_clamped_delta,
    output logic                      o_blocked
);

    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_FIRST = 8'b0000_0100,   // first tile of the span
        S_LAST  = 8'b0000_1000,   // last tile of the span
        S_LINE  = 8'b0001_0000,   // tile line the leading edge enters
        S_SCAN  = 8'b0010_0000,
        S_FLUSH = 8'b0100_0000,   // flush move against the hit tile
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [LOG_W-1:0] r_tile_log2;
    logic             w_cfg_wr;

    // latched item, already swapped so that pos/size lie along the move
    logic                      r_axis;
    logic [POS_W-1:0]          r_pos, r_ppos;
    logic [SIZE_W-1:0]         r_size, r_psize;
    logic signed [DELTA_W-1:0] r_d;
    logic [SHIFT_W-1:0]        r_shift;

    t_idx r_k, n_k;
    t_idx r_last, n_last;
    t_idx r_line, n_line;
    logic [ROW_W-1:0] r_clr_row;

    // scan pipeline: read issued last cycle
    logic             r_pend, n_pend;
    logic             r_pend_oob, n_pend_oob;
    logic [COL_W-1:0] r_pend_col, n_pend_col;

    logic signed [DELTA_W-1:0] r_result, n_result;
    logic                      r_blk, n_blk;

    logic                      r_out_valid;
    logic signed [DELTA_W-1:0] r_out_delta;
    logic                      r_out_blk;

    logic w_accept;
    logic w_load;
    logic w_hit;
    logic w_issue;
    logic w_d_neg;

    t_alu_op   w_op;
    t_alu_word w_sum;
    t_idx      w_idx;
    t_alu_word w_pos_s, w_size_s, w_ppos_s, w_psize_s, w_d_s;

    t_idx w_col_idx, w_row_idx;
    logic w_oob;

    t_mem_ctl             w_mem_ctl;
    logic [ROW_W-1:0]     w_wr_row;
    logic [COL_W-1:0]     w_wr_col;
    logic [ROW_W-1:0]     w_rd_row;
    logic [GRID_COLS-1:0] w_rd_data;
    logic                 w_wr_in_grid;

    // ------------------------------------------------------------------------
    // config port: one register, always ready
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TILE_SIZE);
    assign prdata   = (paddr[2] == REG_TILE_SIZE) ? APB_DW'(r_tile_log2) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_log2 <= TILE_LOG_RST;
        end else if (w_cfg_wr) begin
            r_tile_log2 <= pwdata[LOG_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    // result moves to the output register once it is free or being drained
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // ------------------------------------------------------------------------
    // shared adder / floor-shift unit, operands picked per sequencer step
    // ------------------------------------------------------------------------
    assign w_pos_s   = t_alu_word'(r_pos);
    assign w_size_s  = t_alu_word'(r_size);
    assign w_ppos_s  = t_alu_word'(r_ppos);
    assign w_psize_s = t_alu_word'(r_psize);
    assign w_d_s     = t_alu_word'(r_d);
    assign w_d_neg   = r_d[DELTA_W-1];

    always_comb begin
        w_op = '0;
        case (r_state)
            S_FIRST: begin
                // inset one pixel from the top/left edge
                w_op.a = w_ppos_s;
                w_op.k = t_alu_word'(16);
            end
            S_LAST: begin
                w_op.a = w_ppos_s;
                w_op.b = w_psize_s;
                w_op.k = -t_alu_word'(32);
            end
            S_LINE: begin
                w_op.a = w_pos_s;
                w_op.c = w_d_s;
                if (!w_d_neg) begin
                    w_op.b = w_size_s;
                    w_op.k = -t_alu_word'(16);
                end
            end
            S_FLUSH: begin
                // line * tile edge, less the edge position
                w_op.a = t_alu_word'(r_line) <<< r_shift;
                w_op.b = -w_pos_s;
                if (w_d_neg) begin
                    w_op.c = t_alu_word'(1) << r_shift;
                end else begin
                    w_op.c = -w_size_s;
                end
            end
            default: begin
                w_op = '0;
            end
        endcase
    end

    tgmc_alu u_alu (
        .i_op    (w_op),
        .i_shift (r_shift),
        .o_sum   (w_sum),
        .o_idx   (w_idx)
    );

    // ------------------------------------------------------------------------
    // tile under scan; anything off the grid reads as a wall
    // ------------------------------------------------------------------------
    assign w_col_idx = (r_axis == AXIS_V) ? r_k : r_line;
    assign w_row_idx = (r_axis == AXIS_V) ? r_line : r_k;
    assign w_oob = (w_col_idx < 0) || (w_col_idx >= t_idx'(GRID_COLS)) ||
                   (w_row_idx < 0) || (w_row_idx >= t_idx'(GRID_ROWS));

    assign w_hit   = r_pend && (r_pend_oob || w_rd_data[r_pend_col]);
    assign w_issue = (r_state == S_SCAN) && !w_hit && (r_k <= r_last);

    // ------------------------------------------------------------------------
    // wall memory
    // ------------------------------------------------------------------------
    assign w_wr_in_grid = ({3'b000, i_tile_col} < 9'(GRID_COLS)) &&
                          ({3'b000, i_tile_row} < 9'(GRID_ROWS));

    always_comb begin
        w_mem_ctl     = '0;
        w_mem_ctl.clr = (r_state == S_CLEAR);
        w_mem_ctl.wr  = w_accept && (i_cmd == CMD_WRITE) && w_wr_in_grid;
        w_mem_ctl.rd  = w_issue;
    end

    assign w_wr_row = (r_state == S_CLEAR) ? r_clr_row : ROW_W'(i_tile_row);
    assign w_wr_col = COL_W'(i_tile_col);
    assign w_rd_row = w_row_idx[ROW_W-1:0];

    tgmc_wall_mem #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_row  (w_wr_row),
        .i_wr_col  (w_wr_col),
        .i_wr_bit  (i_wall_bit),
        .i_rd_row  (w_rd_row),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_last     = r_last;
        n_line     = r_line;
        n_pend     = 1'b0;
        n_pend_oob = r_pend_oob;
        n_pend_col = r_pend_col;
        n_result   = r_result;
        n_blk      = r_blk;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_row == ROW_W'(GRID_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_result = '0;
                    n_blk    = 1'b0;
                    if (i_cmd == CMD_CLAMP && i_move_delta != '0) begin
                        n_state = S_FIRST;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIRST: begin
                n_k     = w_idx;
                n_state = S_LAST;
            end
            S_LAST: begin
                n_last  = w_idx;
                n_state = S_LINE;
            end
            S_LINE: begin
                n_line  = w_idx;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_FLUSH;
                end else if (w_issue) begin
                    n_pend     = 1'b1;
                    n_pend_oob = w_oob;
                    n_pend_col = w_col_idx[COL_W-1:0];
                    n_k        = r_k + t_idx'(1);
                end else begin
                    // span done without a wall: move unchanged
                    n_result = r_d;
                    n_state  = S_DONE;
                end
            end
            S_FLUSH: begin
                n_result = sat_delta(w_sum);
                n_blk    = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_last     <= n_last;
        r_line     <= n_line;
        r_pend_oob <= n_pend_oob;
        r_pend_col <= n_pend_col;
        r_result   <= n_result;
        r_blk      <= n_blk;
        if (w_accept) begin
            r_axis  <= i_axis;
            r_d     <= i_move_delta;
            r_shift <= tile_shift(r_tile_log2);
            if (i_axis == AXIS_V) begin
                r_pos   <= i_box_y;
                r_size  <= i_box_h;
                r_ppos  <= i_box_x;
                r_psize <= i_box_w;
            end else begin
                r_pos   <= i_box_x;
                r_size  <= i_box_w;
                r_ppos  <= i_box_y;
                r_psize <= i_box_h;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_delta <= r_result;
            r_out_blk   <= r_blk;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_clamped_delta = r_out_delta;
    assign o_blocked       = r_out_blk;

`ifndef SYNTHESIS
    // a transfer always leaves the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input taken twice in a row");

    // nothing goes in or out during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (o_in_stall && !o_out_valid))
        else $error("activity during map clear");

    // a new result only ever comes from the done step
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result without done step");

    // map writes and scan reads never share a cycle
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_ctl.rd && (w_mem_ctl.wr || w_mem_ctl.clr)))
        else $error("wall map read and write collide");
`endif

endmodule
